@@ hdl/dsa_pkg.sv @@
// Shared types, operand codes and modular helpers for the DSA signer.
`default_nettype none
package dsa_pkg;

  localparam int W     = 32;
  localparam int CNT_W = 6;
  localparam logic [W-1:0] HASH_KEY = 32'd1234;

  localparam logic [W-1:0] RST_P = 32'd23;
  localparam logic [W-1:0] RST_Q = 32'd11;
  localparam logic [W-1:0] RST_H = 32'd2;
  localparam logic [W-1:0] RST_X = 32'd3;

  // config register indexes
  localparam logic [1:0] REG_P = 2'd0;
  localparam logic [1:0] REG_Q = 2'd1;
  localparam logic [1:0] REG_H = 2'd2;
  localparam logic [1:0] REG_X = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_PQ = 2'd1;
  localparam logic [1:0] ST_BAD_G  = 2'd2;
  localparam logic [1:0] ST_NO_INV = 2'd3;

  // operand sources
  localparam logic [4:0] SRC_ZERO  = 5'd0;
  localparam logic [4:0] SRC_ONE   = 5'd1;
  localparam logic [4:0] SRC_PM1   = 5'd2;
  localparam logic [4:0] SRC_Q     = 5'd3;
  localparam logic [4:0] SRC_P     = 5'd4;
  localparam logic [4:0] SRC_H     = 5'd5;
  localparam logic [4:0] SRC_X     = 5'd6;
  localparam logic [4:0] SRC_K     = 5'd7;
  localparam logic [4:0] SRC_HASH  = 5'd8;
  localparam logic [4:0] SRC_QUO   = 5'd9;
  localparam logic [4:0] SRC_REM   = 5'd10;
  localparam logic [4:0] SRC_MUL   = 5'd11;
  localparam logic [4:0] SRC_BASE  = 5'd12;
  localparam logic [4:0] SRC_RES   = 5'd13;
  localparam logic [4:0] SRC_E     = 5'd14;
  localparam logic [4:0] SRC_G     = 5'd15;
  localparam logic [4:0] SRC_R     = 5'd16;
  localparam logic [4:0] SRC_R0    = 5'd17;
  localparam logic [4:0] SRC_R1    = 5'd18;
  localparam logic [4:0] SRC_T0    = 5'd19;
  localparam logic [4:0] SRC_T1    = 5'd20;
  localparam logic [4:0] SRC_TMP   = 5'd21;
  localparam logic [4:0] SRC_ESHR  = 5'd22;
  localparam logic [4:0] SRC_QTRED = 5'd23;
  localparam logic [4:0] SRC_ADDQ  = 5'd24;
  localparam logic [4:0] SRC_SUBQ  = 5'd25;

  // write destinations
  localparam logic [3:0] DST_BASE = 4'd0;
  localparam logic [3:0] DST_RES  = 4'd1;
  localparam logic [3:0] DST_E    = 4'd2;
  localparam logic [3:0] DST_G    = 4'd3;
  localparam logic [3:0] DST_Y    = 4'd4;
  localparam logic [3:0] DST_R    = 4'd5;
  localparam logic [3:0] DST_R0   = 4'd6;
  localparam logic [3:0] DST_R1   = 4'd7;
  localparam logic [3:0] DST_T0   = 4'd8;
  localparam logic [3:0] DST_T1   = 4'd9;
  localparam logic [3:0] DST_TMP  = 4'd10;
  localparam logic [3:0] DST_S    = 4'd11;

  typedef struct packed {
    logic       load;
    logic       wr_en;
    logic [3:0] wr_dst;
    logic [4:0] wr_src;
    logic       div_start;
    logic [4:0] div_a;
    logic [4:0] div_b;
    logic       mul_start;
    logic [4:0] mul_a;
    logic [4:0] mul_b;
    logic       mul_mod_q;
    logic       out_load;
    logic [1:0] out_status;
  } dsa_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mul_busy;
    logic rem_zero;
    logic e_zero;
    logic e_lsb;
    logic r1_zero;
    logic r0_one;
    logic g_le1;
    logic pq_bad;
    logic out_hold;
  } dsa_stat_t;

  // (x + y) mod m with x, y < m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] sum;
    logic [W:0] dif;
    sum = {1'b0, x} + {1'b0, y};
    dif = sum - {1'b0, m};
    return (sum >= {1'b0, m}) ? dif[W-1:0] : sum[W-1:0];
  endfunction

  // (x - y) mod m with x, y < m
  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    return (x >= y) ? (x - y) : (x + (m - y));
  endfunction

endpackage
`default_nettype wire

@@ hdl/dsa_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module dsa_div (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire  [dsa_pkg::W-1:0]  dividend,
  input  wire  [dsa_pkg::W-1:0]  divisor,
  output logic                   busy,
  output logic [dsa_pkg::W-1:0]  quo,
  output logic [dsa_pkg::W-1:0]  rem
);
  import dsa_pkg::*;

  logic [W-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic [W:0]     rem_sh;
  logic [W:0]     rem_sub;

  assign rem_sh  = {rem, quo[W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(W);
      dvs  <= divisor;
      quo  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sub[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hdl/dsa_mulmod.sv @@
// Shift-and-add modular multiplier, one multiplier bit per cycle.
`default_nettype none
module dsa_mulmod (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire  [dsa_pkg::W-1:0]  a,
  input  wire  [dsa_pkg::W-1:0]  b,
  input  wire  [dsa_pkg::W-1:0]  m,
  output logic                   busy,
  output logic [dsa_pkg::W-1:0]  acc
);
  import dsa_pkg::*;

  logic [W-1:0]     a_r;
  logic [W-1:0]     b_r;
  logic [W-1:0]     m_r;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(W);
      a_r  <= a;
      b_r  <= b;
      m_r  <= m;
      acc  <= '0;
    end else if (busy) begin
      if (b_r[0]) acc <= add_mod(acc, a_r, m_r);
      a_r <= add_mod(a_r, a_r, m_r);
      b_r <= b_r >> 1;
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hdl/dsa_datapath.sv @@
// Datapath: config, working registers, shared divide and multiply units, output register.
`default_nettype none
module dsa_datapath (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire  [1:0]             cfg_index,
  input  wire  [dsa_pkg::W-1:0]  cfg_data,
  input  wire  [dsa_pkg::W-1:0]  message,
  input  wire  [dsa_pkg::W-1:0]  nonce,
  input  wire                    out_stall,
  input  wire  dsa_pkg::dsa_cmd_t cmd,
  output dsa_pkg::dsa_stat_t     stat,
  output logic                   out_valid,
  output logic [1:0]             status,
  output logic [dsa_pkg::W-1:0]  generator,
  output logic [dsa_pkg::W-1:0]  public_key,
  output logic [dsa_pkg::W-1:0]  sig_r,
  output logic [dsa_pkg::W-1:0]  sig_s
);
  import dsa_pkg::*;

  logic [W-1:0] p, q, h, x;
  logic [W-1:0] msg, k;
  logic [W-1:0] base, res, e, g, y, r, r0, r1, t0, t1, tmp, s;
  logic [W-1:0] quo, rem, mul;
  logic         div_busy, mul_busy;
  logic [W-1:0] div_a, div_b, mul_a, mul_b, wr_val;

  function automatic logic [W-1:0] src(input logic [4:0] sel);
    case (sel)
      SRC_ZERO:  return '0;
      SRC_ONE:   return W'(1);
      SRC_PM1:   return p - 1'b1;
      SRC_Q:     return q;
      SRC_P:     return p;
      SRC_H:     return h;
      SRC_X:     return x;
      SRC_K:     return k;
      SRC_HASH:  return msg ^ HASH_KEY;
      SRC_QUO:   return quo;
      SRC_REM:   return rem;
      SRC_MUL:   return mul;
      SRC_BASE:  return base;
      SRC_RES:   return res;
      SRC_E:     return e;
      SRC_G:     return g;
      SRC_R:     return r;
      SRC_R0:    return r0;
      SRC_R1:    return r1;
      SRC_T0:    return t0;
      SRC_T1:    return t1;
      SRC_TMP:   return tmp;
      SRC_ESHR:  return e >> 1;
      SRC_QTRED: return (quo >= q) ? (quo - q) : quo;
      SRC_ADDQ:  return add_mod(tmp, mul, q);
      SRC_SUBQ:  return sub_mod(t0, mul, q);
      default:   return '0;
    endcase
  endfunction

  assign div_a  = src(cmd.div_a);
  assign div_b  = src(cmd.div_b);
  assign mul_a  = src(cmd.mul_a);
  assign mul_b  = src(cmd.mul_b);
  assign wr_val = src(cmd.wr_src);

  dsa_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quo(quo), .rem(rem)
  );

  dsa_mulmod u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(mul_a), .b(mul_b),
    .m(cmd.mul_mod_q ? q : p), .busy(mul_busy), .acc(mul)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= RST_P;
      q <= RST_Q;
      h <= RST_H;
      x <= RST_X;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_P:   p <= cfg_data;
        REG_Q:   q <= cfg_data;
        REG_H:   h <= cfg_data;
        REG_X:   x <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      msg <= message;
      k   <= nonce;
      g   <= '0;
      y   <= '0;
      r   <= '0;
      s   <= '0;
    end else if (cmd.wr_en) begin
      case (cmd.wr_dst)
        DST_BASE: base <= wr_val;
        DST_RES:  res  <= wr_val;
        DST_E:    e    <= wr_val;
        DST_G:    g    <= wr_val;
        DST_Y:    y    <= wr_val;
        DST_R:    r    <= wr_val;
        DST_R0:   r0   <= wr_val;
        DST_R1:   r1   <= wr_val;
        DST_T0:   t0   <= wr_val;
        DST_T1:   t1   <= wr_val;
        DST_TMP:  tmp  <= wr_val;
        DST_S:    s    <= wr_val;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= cmd.out_status;
      generator  <= g;
      public_key <= y;
      sig_r      <= r;
      sig_s      <= s;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.mul_busy = mul_busy;
  assign stat.rem_zero = (rem == '0);
  assign stat.e_zero   = (e == '0);
  assign stat.e_lsb    = e[0];
  assign stat.r1_zero  = (r1 == '0);
  assign stat.r0_one   = (r0 == W'(1));
  assign stat.g_le1    = (g <= W'(1));
  assign stat.pq_bad   = (q < W'(3)) || (p < W'(2));
  assign stat.out_hold = out_valid && out_stall;
endmodule
`default_nettype wire

@@ hdl/dsa_ctrl.sv @@
// Sequencer that drives the datapath through checks, derivation, exponentiations, inverse and signature.
`default_nettype none
module dsa_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  dsa_pkg::dsa_stat_t stat,
  output dsa_pkg::dsa_cmd_t       cmd
);
  import dsa_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0,  S_CHK  = 6'd1,  S_GDIV = 6'd2,  S_GB   = 6'd3;
  localparam logic [5:0] S_GB2  = 6'd4,  S_GR   = 6'd5,  S_GEND = 6'd6,  S_GCHK = 6'd7;
  localparam logic [5:0] S_Y1   = 6'd8,  S_Y2   = 6'd9,  S_YEND = 6'd10, S_R1   = 6'd11;
  localparam logic [5:0] S_R2   = 6'd12, S_R3   = 6'd13, S_REND = 6'd14, S_RSET = 6'd15;
  localparam logic [5:0] S_I1   = 6'd16, S_I2   = 6'd17, S_I3   = 6'd18, S_I4   = 6'd19;
  localparam logic [5:0] S_I5   = 6'd20, S_ICHK = 6'd21, S_IQ   = 6'd22, S_IT   = 6'd23;
  localparam logic [5:0] S_IS1  = 6'd24, S_IS2  = 6'd25, S_IS3  = 6'd26, S_IS4  = 6'd27;
  localparam logic [5:0] S_IEND = 6'd28, S_H2   = 6'd29, S_X1   = 6'd30, S_X2   = 6'd31;
  localparam logic [5:0] S_X3   = 6'd32, S_S1   = 6'd33, S_S2   = 6'd34, S_FIN  = 6'd35;
  localparam logic [5:0] S_DW   = 6'd36, S_MW   = 6'd37, PW_CHK = 6'd38, PW_M1  = 6'd39;
  localparam logic [5:0] PW_M1S = 6'd40, PW_M2  = 6'd41, PW_M2S = 6'd42, PW_SH  = 6'd43;

  logic [5:0] state, state_next;
  logic [5:0] ret, ret_next;
  logic [5:0] pow_ret, pow_ret_next;
  logic [1:0] stat_code, stat_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      pow_ret   <= S_IDLE;
      stat_code <= ST_OK;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      pow_ret   <= pow_ret_next;
      stat_code <= stat_code_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    pow_ret_next   = pow_ret;
    stat_code_next = stat_code;
    cmd            = '0;
    cmd.out_status = stat_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.pq_bad) begin
          stat_code_next = ST_BAD_PQ;
          state_next     = S_FIN;
        end else begin
          cmd.div_start = 1'b1; cmd.div_a = SRC_PM1; cmd.div_b = SRC_Q;
          ret_next = S_GDIV; state_next = S_DW;
        end
      end
      S_GDIV: begin
        if (!stat.rem_zero) begin
          stat_code_next = ST_BAD_PQ;
          state_next     = S_FIN;
        end else begin
          cmd.wr_en = 1'b1; cmd.wr_dst = DST_E; cmd.wr_src = SRC_QUO;
          state_next = S_GB;
        end
      end
      S_GB: begin
        cmd.div_start = 1'b1; cmd.div_a = SRC_H; cmd.div_b = SRC_P;
        ret_next = S_GB2; state_next = S_DW;
      end
      S_GB2: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_BASE; cmd.wr_src = SRC_REM;
        state_next = S_GR;
      end
      S_GR: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_RES; cmd.wr_src = SRC_ONE;
        pow_ret_next = S_GEND; state_next = PW_CHK;
      end
      S_GEND: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_G; cmd.wr_src = SRC_RES;
        state_next = S_GCHK;
      end
      S_GCHK: begin
        if (stat.g_le1) begin
          stat_code_next = ST_BAD_G;
          state_next     = S_FIN;
        end else begin
          cmd.wr_en = 1'b1; cmd.wr_dst = DST_BASE; cmd.wr_src = SRC_G;
          state_next = S_Y1;
        end
      end
      S_Y1: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_E; cmd.wr_src = SRC_X;
        state_next = S_Y2;
      end
      S_Y2: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_RES; cmd.wr_src = SRC_ONE;
        pow_ret_next = S_YEND; state_next = PW_CHK;
      end
      S_YEND: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_Y; cmd.wr_src = SRC_RES;
        state_next = S_R1;
      end
      S_R1: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_BASE; cmd.wr_src = SRC_G;
        state_next = S_R2;
      end
      S_R2: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_E; cmd.wr_src = SRC_K;
        state_next = S_R3;
      end
      S_R3: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_RES; cmd.wr_src = SRC_ONE;
        pow_ret_next = S_REND; state_next = PW_CHK;
      end
      S_REND: begin
        cmd.div_start = 1'b1; cmd.div_a = SRC_RES; cmd.div_b = SRC_Q;
        ret_next = S_RSET; state_next = S_DW;
      end
      S_RSET: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_R; cmd.wr_src = SRC_REM;
        state_next = S_I1;
      end
      // extended Euclid for k^-1 mod q
      S_I1: begin
        cmd.div_start = 1'b1; cmd.div_a = SRC_K; cmd.div_b = SRC_Q;
        ret_next = S_I2; state_next = S_DW;
      end
      S_I2: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_R1; cmd.wr_src = SRC_REM;
        state_next = S_I3;
      end
      S_I3: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_R0; cmd.wr_src = SRC_Q;
        state_next = S_I4;
      end
      S_I4: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_T0; cmd.wr_src = SRC_ZERO;
        state_next = S_I5;
      end
      S_I5: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_T1; cmd.wr_src = SRC_ONE;
        state_next = S_ICHK;
      end
      S_ICHK: begin
        if (stat.r1_zero) begin
          state_next = S_IEND;
        end else begin
          cmd.div_start = 1'b1; cmd.div_a = SRC_R0; cmd.div_b = SRC_R1;
          ret_next = S_IQ; state_next = S_DW;
        end
      end
      S_IQ: begin
        cmd.mul_start = 1'b1; cmd.mul_a = SRC_QTRED; cmd.mul_b = SRC_T1;
        cmd.mul_mod_q = 1'b1;
        ret_next = S_IT; state_next = S_MW;
      end
      S_IT: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_TMP; cmd.wr_src = SRC_SUBQ;
        state_next = S_IS1;
      end
      S_IS1: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_T0; cmd.wr_src = SRC_T1;
        state_next = S_IS2;
      end
      S_IS2: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_T1; cmd.wr_src = SRC_TMP;
        state_next = S_IS3;
      end
      S_IS3: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_R0; cmd.wr_src = SRC_R1;
        state_next = S_IS4;
      end
      S_IS4: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_R1; cmd.wr_src = SRC_REM;
        state_next = S_ICHK;
      end
      S_IEND: begin
        if (!stat.r0_one) begin
          stat_code_next = ST_NO_INV;
          state_next     = S_FIN;
        end else begin
          cmd.div_start = 1'b1; cmd.div_a = SRC_HASH; cmd.div_b = SRC_Q;
          ret_next = S_H2; state_next = S_DW;
        end
      end
      S_H2: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_TMP; cmd.wr_src = SRC_REM;
        state_next = S_X1;
      end
      S_X1: begin
        cmd.div_start = 1'b1; cmd.div_a = SRC_X; cmd.div_b = SRC_Q;
        ret_next = S_X2; state_next = S_DW;
      end
      S_X2: begin
        cmd.mul_start = 1'b1; cmd.mul_a = SRC_REM; cmd.mul_b = SRC_R;
        cmd.mul_mod_q = 1'b1;
        ret_next = S_X3; state_next = S_MW;
      end
      S_X3: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_TMP; cmd.wr_src = SRC_ADDQ;
        state_next = S_S1;
      end
      S_S1: begin
        cmd.mul_start = 1'b1; cmd.mul_a = SRC_T0; cmd.mul_b = SRC_TMP;
        cmd.mul_mod_q = 1'b1;
        ret_next = S_S2; state_next = S_MW;
      end
      S_S2: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_S; cmd.wr_src = SRC_MUL;
        stat_code_next = ST_OK;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_hold) begin
          cmd.out_load   = 1'b1;
          stat_code_next = ST_OK;
          state_next     = S_IDLE;
        end
      end
      S_DW: begin
        if (!stat.div_busy) state_next = ret;
      end
      S_MW: begin
        if (!stat.mul_busy) state_next = ret;
      end
      // square-and-multiply: res = res * base^e mod p
      PW_CHK: begin
        if (stat.e_zero)     state_next = pow_ret;
        else if (stat.e_lsb) state_next = PW_M1;
        else                 state_next = PW_M2;
      end
      PW_M1: begin
        cmd.mul_start = 1'b1; cmd.mul_a = SRC_RES; cmd.mul_b = SRC_BASE;
        ret_next = PW_M1S; state_next = S_MW;
      end
      PW_M1S: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_RES; cmd.wr_src = SRC_MUL;
        state_next = PW_M2;
      end
      PW_M2: begin
        cmd.mul_start = 1'b1; cmd.mul_a = SRC_BASE; cmd.mul_b = SRC_BASE;
        ret_next = PW_M2S; state_next = S_MW;
      end
      PW_M2S: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_BASE; cmd.wr_src = SRC_MUL;
        state_next = PW_SH;
      end
      PW_SH: begin
        cmd.wr_en = 1'b1; cmd.wr_dst = DST_E; cmd.wr_src = SRC_ESHR;
        state_next = PW_CHK;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/dsa_signature_generator_top.sv @@
// DSA signature generator: one signature item per message/nonce item.
//
// Config: cfg_we/cfg_index/cfg_data write p (0), q (1), seed h (2), key x (3);
//   write only while the block is idle. Reset loads p=23, q=11, h=2, x=3.
// Input channel: in_valid/in_stall with message and nonce. An item is taken
//   when in_valid is high and in_stall low; in_stall stays high while an
//   item is being worked on (one item at a time).
// Output channel: out_valid/out_stall with status, generator, public_key,
//   sig_r, sig_s. The result sits in an output register, so the next item
//   is taken while a finished one waits; if the receiver stalls and a second
//   result is ready, the sequencer holds until the first is taken.
// Work: every modular multiply runs on a shared 32-step multiply unit and
//   every divide/remainder on a shared 32-step divide unit. g, y and g^k are
//   square-and-multiply over the exponent bits (up to 64 unit passes each),
//   then extended Euclid for k^-1 needs one divide plus one multiply per
//   round. Errors in p or q are found before any exponentiation.
// Reset: synchronous, active high; clears control and the output valid.
`default_nettype none
module dsa_signature_generator_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] message,
  input  wire  [31:0] nonce,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  status,
  output logic [31:0] generator,
  output logic [31:0] public_key,
  output logic [31:0] sig_r,
  output logic [31:0] sig_s
);
  import dsa_pkg::*;

  dsa_cmd_t  cmd;
  dsa_stat_t stat;

  // sequencer: owns the input handshake and the step order
  dsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  // datapath: registers, divide and multiply units, output register
  dsa_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .message(message), .nonce(nonce), .out_stall(out_stall),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .status(status), .generator(generator),
    .public_key(public_key), .sig_r(sig_r), .sig_s(sig_s)
  );
endmodule
`default_nettype wire

@@ test/dsa_signature_generator_top_tb.sv @@
// Testbench for the DSA signer: scoreboard prediction, random stalls, config sweeps.
`timescale 1ns / 1ps
`default_nettype none

// Predicted signature for one message/nonce item.
typedef struct {
  logic [1:0]  status;
  logic [31:0] generator;
  logic [31:0] public_key;
  logic [31:0] sig_r;
  logic [31:0] sig_s;
} sig_result_t;

class dsa_signer_scoreboard;
  logic [31:0] p, q, h, x;
  sig_result_t pending_sigs[$];
  int          n_errors;
  int          n_checked;
  int          status_seen[4];

  function new();
    p = dsa_pkg::RST_P;
    q = dsa_pkg::RST_Q;
    h = dsa_pkg::RST_H;
    x = dsa_pkg::RST_X;
    n_errors = 0;
    n_checked = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      dsa_pkg::REG_P: p = val;
      dsa_pkg::REG_Q: q = val;
      dsa_pkg::REG_H: h = val;
      dsa_pkg::REG_X: x = val;
      default: ;
    endcase
  endfunction

  // exact 64-bit arithmetic; all operands stay below 2^32
  function logic [63:0] modexp(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  // modular inverse by extended Euclid; returns 0 in ok when none exists
  function logic [63:0] modinv(logic [63:0] k, logic [63:0] m, output bit ok);
    logic [63:0] r0, r1, t0, t1, qt, rn, tn;
    r0 = m; r1 = k % m; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      rn = r0 - qt * r1;
      tn = (t0 + m - ((qt % m) * t1) % m) % m;
      r0 = r1; r1 = rn; t0 = t1; t1 = tn;
    end
    ok = (r0 == 1);
    return t0;
  endfunction

  function void note_item(logic [31:0] msg, logic [31:0] k);
    sig_result_t e;
    logic [63:0] g, r, inv, hsh, t;
    bit ok;
    e = '{default: '0};
    if (q < 3 || p < 2 || ((64'(p) - 1) % q) != 0) begin
      e.status = dsa_pkg::ST_BAD_PQ;
    end else begin
      g = modexp(64'(h), (64'(p) - 1) / q, 64'(p));
      e.generator = g[31:0];
      if (g <= 1) begin
        e.status = dsa_pkg::ST_BAD_G;
      end else begin
        e.public_key = 32'(modexp(g, 64'(x), 64'(p)));
        r = modexp(g, 64'(k), 64'(p)) % q;
        e.sig_r = r[31:0];
        inv = modinv(64'(k), 64'(q), ok);
        if (!ok) begin
          e.status = dsa_pkg::ST_NO_INV;
        end else begin
          hsh = 64'(msg ^ dsa_pkg::HASH_KEY) % q;
          t = (hsh + (64'(x) % q) * r % q) % q;
          e.sig_s = 32'((inv * t) % q);
          e.status = dsa_pkg::ST_OK;
        end
      end
    end
    pending_sigs.push_back(e);
  endfunction

  function void check_result(sig_result_t got);
    sig_result_t e;
    if (pending_sigs.size() == 0) begin
      $error("unexpected result item, status %0d", got.status);
      n_errors++;
      return;
    end
    e = pending_sigs.pop_front();
    n_checked++;
    status_seen[got.status]++;
    if (got.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, got.status); n_errors++;
    end
    if (got.generator !== e.generator) begin
      $error("generator: expected %0d, got %0d", e.generator, got.generator); n_errors++;
    end
    if (got.public_key !== e.public_key) begin
      $error("public_key: expected %0d, got %0d", e.public_key, got.public_key); n_errors++;
    end
    if (got.sig_r !== e.sig_r) begin
      $error("sig_r: expected %0d, got %0d", e.sig_r, got.sig_r); n_errors++;
    end
    if (got.sig_s !== e.sig_s) begin
      $error("sig_s: expected %0d, got %0d", e.sig_s, got.sig_s); n_errors++;
    end
  endfunction
endclass

module dsa_signature_generator_top_tb;
  import dsa_pkg::*;

  localparam int TIMEOUT_CYCLES = 10_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] message = '0;
  logic [31:0] nonce = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  status;
  logic [31:0] generator, public_key, sig_r, sig_s;

  dsa_signature_generator_top u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .message, .nonce,
    .out_valid, .out_stall, .status, .generator, .public_key, .sig_r, .sig_s
  );

  always #5 clk = ~clk;

  dsa_signer_scoreboard sb = new();

  // idle percentages; the sink process reads its own
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;   // one-shot long receiver stall, set by the stimulus
  int cycle_count = 0;
  int items_sent = 0;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: sample at the rising edge, retune stall at the falling edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{status, generator, public_key, sig_r, sig_s});
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b1;
    end else if (hold_off_cycles > 0) begin
      // long hold-off so the block backs up and stalls its input
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_group(logic [31:0] p, logic [31:0] q, logic [31:0] h, logic [31:0] x);
    write_reg(REG_P, p);
    write_reg(REG_Q, q);
    write_reg(REG_H, h);
    write_reg(REG_X, x);
  endtask

  // Offer one item; valid stays up until accepted, optional idle gap first.
  task automatic send_sig_request(logic [31:0] msg, logic [31:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    message <= msg;
    nonce <= k;
    do @(posedge clk); while (in_stall);
    sb.note_item(msg, k);
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Block is idle when nothing is pending; let the last item fully settle.
  task automatic drain();
    while (sb.pending_sigs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // random nonce, mostly inside [1, q-1] but sometimes full range
  function automatic logic [31:0] pick_nonce();
    if ($urandom_range(3) == 0) return $urandom();
    return (sb.q > 2) ? $urandom_range(sb.q - 1, 1) : $urandom();
  endfunction

  // Known-good DSA groups (q prime dividing p-1).
  logic [31:0] grp_p[4] = '{32'd23, 32'd607, 32'd2147483647, 32'd4294967291};
  logic [31:0] grp_q[4] = '{32'd11, 32'd101, 32'd7, 32'd5};

  initial begin
    int g, n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset config, field extremes, each status.
    recv_idle_pct = 0;
    send_sig_request(32'd0, 32'd0);            // k mod q zero: not invertible
    send_sig_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sig_request(32'd1234, 32'd5);         // hash zero
    send_sig_request(32'h5555_AAAA, 32'd11);   // k equal to q
    send_sig_request(32'hAAAA_5555, 32'd1);
    drain();
    load_group(32'd23, 32'd11, 32'd1, 32'd3);  // h=1 gives g=1
    send_sig_request(32'd7, 32'd3);
    drain();
    load_group(32'd23, 32'd11, 32'd0, 32'd3);  // g=0
    send_sig_request(32'd7, 32'd3);
    drain();
    load_group(32'd23, 32'd2, 32'd2, 32'd3);   // q below 3
    send_sig_request(32'd7, 32'd3);
    drain();
    load_group(32'd1, 32'd11, 32'd2, 32'd3);   // p below 2
    send_sig_request(32'd7, 32'd3);
    drain();
    load_group(32'd29, 32'd11, 32'd2, 32'd3);  // q does not divide p-1
    send_sig_request(32'd7, 32'd3);
    drain();
    load_group(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sig_request(32'd1, 32'd2);
    drain();
    load_group(32'd0, 32'd0, 32'd0, 32'd0);
    send_sig_request(32'd1, 32'd2);
    drain();
    load_group(32'd4294967291, 32'd5, 32'd3, 32'hFFFF_FFFF); // full-width key
    send_sig_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sig_request(32'd0, 32'd4);
    drain();

    // Random phases: sender busy / receiver busy, swapped, then no idling.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 37 : 0;
      for (int c = 0; c < 4; c++) begin
        g = $urandom_range(3);
        if ($urandom_range(7) == 0)
          load_group($urandom(), $urandom_range(20, 0), $urandom(), $urandom());
        else
          load_group(grp_p[g], grp_q[g], $urandom_range(1000, 0),
                     ($urandom_range(1)) ? $urandom() : $urandom_range(grp_q[g], 2));
        if (ph == 1 && c == 0) hold_off_cycles = 30000;
        n = 8;
        for (int i = 0; i < n; i++)
          send_sig_request($urandom(), pick_nonce());
        drain();
      end
    end

    $display("Covered %0d items over several groups; status counts ok=%0d badpq=%0d",
             items_sent, sb.status_seen[ST_OK], sb.status_seen[ST_BAD_PQ]);
    $display("badg=%0d noinv=%0d; %0d results checked, %0d mismatches",
             sb.status_seen[ST_BAD_G], sb.status_seen[ST_NO_INV], sb.n_checked,
             sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_sigs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ filelist.f @@
hdl/dsa_pkg.sv
hdl/dsa_div.sv
hdl/dsa_mulmod.sv
hdl/dsa_datapath.sv
hdl/dsa_ctrl.sv
hdl/dsa_signature_generator_top.sv
test/dsa_signature_generator_top_tb.sv
